// File: src/led_fade_and_breathe_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// LED fade/breathe engine assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LED_FADE_AND_BREATHE_ENGINE_UNIT_MACROS_SVH
`define LED_FADE_AND_BREATHE_ENGINE_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define LFBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define LFBE_IMPLIES(lbl, a, b, msg) \
  `LFBE_ASSERT(lbl, (a) |-> (b), msg)

`endif

// File: src/lfbe_pkg.sv
// ----------------------------------------------------------------------------
// lfbe_pkg
// Constants, opcodes and channel record type of the LED fade/breathe engine.
// ----------------------------------------------------------------------------
package lfbe_pkg;

  localparam int CHANNELS    = 3;
  localparam int TABLE_DEPTH = 256;
  localparam int FULL_LEVEL  = 10000;

  localparam int CH_W    = $clog2(CHANNELS);
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int LEVEL_W = 14;
  localparam int FREQ_W  = 10;
  localparam int WAVE_W  = 25;
  localparam int DIV_NW  = 28;
  localparam int DIV_DW  = 14;
  localparam int DIV_CW  = $clog2(DIV_NW + 1);

  // x / FULL_LEVEL as ((x >> PROD_SHIFT) * LVL_RECIP) >> LVL_SHIFT, exact for x < 2**28
  localparam int PROD_SHIFT = 4;
  localparam int RECIP_W    = 25;
  localparam int LVL_SHIFT  = 34;
  localparam logic [RECIP_W-1:0] LVL_RECIP = RECIP_W'(27487791);

  localparam logic [FREQ_W-1:0]  RESET_FREQ  = FREQ_W'(1000);
  localparam logic [LEVEL_W-1:0] RESET_LEVEL = LEVEL_W'(5000);
  // waves per sample for a 5000 ms period at 1000 Hz
  localparam logic [WAVE_W-1:0]  RESET_WAVES = WAVE_W'(20);
  localparam int MS_PER_S = 1000;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_TARGET = 3'd1;
  localparam logic [2:0] OP_PERIOD = 3'd2;
  localparam logic [2:0] OP_MODE   = 3'd3;
  localparam logic [2:0] OP_LUT    = 3'd4;

  typedef struct packed {
    logic [LEVEL_W-1:0] tgt;
    logic [LEVEL_W-1:0] cur;
    logic [LEVEL_W-1:0] step;
    logic               pending;
    logic               mode;
    logic [WAVE_W-1:0]  waves;
    logic [WAVE_W-1:0]  count;
    logic [IDX_W-1:0]   index;
  } chan_rec_t;

  localparam chan_rec_t RESET_REC = '{
    tgt: RESET_LEVEL, cur: '0, step: '0, pending: 1'b1, mode: 1'b0,
    waves: RESET_WAVES, count: '0, index: '0};

endpackage

// File: src/lfbe_ram.sv
// ----------------------------------------------------------------------------
// lfbe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lfbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/lfbe_div.sv
// ----------------------------------------------------------------------------
// lfbe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfbe_div
  import lfbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              busy,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  logic [DIV_DW:0]   rem;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW:0]   shifted;

  assign shifted = {rem[DIV_DW-1:0], quo[DIV_NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= num;
        dsr  <= den;
        rem  <= '0;
        cnt  <= DIV_CW'(DIV_NW);
      end else if (busy) begin
        if (shifted >= {1'b0, dsr}) begin
          rem <= shifted - {1'b0, dsr};
          quo <= {quo[DIV_NW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[DIV_NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/led_fade_and_breathe_engine_unit.sv
// ----------------------------------------------------------------------------
// led_fade_and_breathe_engine_unit
// Three-channel LED fade and breathe engine with APB frequency register.
// ----------------------------------------------------------------------------
// One item is handled at a time; the next beat is taken the cycle after the
// result is loaded. A tick visits the three channels in turn, reading each
// record from the channel memory: a channel at rest (or breathing with
// zero waves per sample) is not written back, a channel ramping with a known
// step is stepped and written back, one whose new fade step must be divided
// out first waits on a division, and a breathe channel adds a table read, a
// multiply and a reciprocal scale before its write-back. The result then
// waits out any output stall. The shared 28-bit divider serves fade steps and
// breathe period writes, which take two divisions; a zero period sets status.
// Target and mode writes update the record (not an ignored mode); table
// writes and unknown opcodes go straight out. The breathe table is cleared at
// reset through per-entry valid bits, so no clearing pass is needed.
module led_fade_and_breathe_engine_unit
  import lfbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // channel[1:0], value[33:2], lut_address[41:34], zero fill
  input  logic [47:0] s_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // duty_first[13:0], duty_second[27:14], duty_third[41:28], write_first[42],
  // write_second[43], write_third[44], applied_level[58:45], zero fill
  output logic [63:0] m_tdata,
  // status[0]
  output logic [0:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "led_fade_and_breathe_engine_unit_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_CRD, S_CGET, S_FADE, S_TRD, S_TGET, S_MUL, S_LVL, S_DIV, S_CWR,
    S_NEXT, S_OUT
  } state_t;

  typedef enum logic [1:0] {K_MS, K_WAVES, K_STEP} div_kind_t;

  state_t            state;
  div_kind_t         div_kind;
  logic [FREQ_W-1:0] freq;
  logic [2:0]        op;
  logic [CH_W-1:0]   ch;
  logic [CH_W-1:0]   c;
  logic [31:0]       val;
  chan_rec_t         rec;
  chan_rec_t         rd_rec;
  chan_rec_t         cget_rec;
  chan_rec_t         chan_rdata;
  logic [CHANNELS-1:0]    chan_vld;
  logic [TABLE_DEPTH-1:0] tbl_vld;
  logic [LEVEL_W-1:0] tbl_rdata;
  logic [LEVEL_W-1:0] tbl_word;
  logic [DIV_NW-1:0]  prod;
  logic [DIV_NW-PROD_SHIFT+RECIP_W-1:0] lvl_prod;
  logic [FREQ_W-1:0]  ms_q;
  logic [WAVE_W-1:0]  waves_new;
  logic [LEVEL_W-1:0] duty [CHANNELS];
  logic [CHANNELS-1:0] wr;
  logic               status;
  logic [LEVEL_W-1:0] applied;

  logic              div_start;
  logic              div_go;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_busy;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;

  logic              accept;
  logic              out_load;
  logic              cfg_we;
  logic [FREQ_W-1:0] freq_eff;
  logic [CH_W-1:0]   ch_in;
  logic [CH_W-1:0]   chan_addr;
  logic              chan_we;
  logic              tbl_we;
  logic [LEVEL_W-1:0] diff;
  logic [LEVEL_W-1:0] step_use;
  logic [LEVEL_W-1:0] clamp;
  logic [WAVE_W-1:0]  count_inc;
  logic [32:0]        wave_num;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && !paddr[2];
  assign prdata   = paddr[2] ? 32'd0 : {{(32 - FREQ_W){1'b0}}, freq};
  assign freq_eff = (freq == '0) ? FREQ_W'(1) : freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= RESET_FREQ;
    end else if (cfg_we) begin
      freq <= pwdata[FREQ_W-1:0];
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign ch_in     = (s_tdata[1:0] >= 2'(CHANNELS)) ? '0 : CH_W'(s_tdata[1:0]);
  assign chan_addr = (op == OP_TICK) ? c : ch;
  assign chan_we   = (state == S_CWR);
  assign tbl_we    = accept && (s_tuser == OP_LUT);

  lfbe_ram #(.WIDTH($bits(chan_rec_t)), .DEPTH(CHANNELS)) u_chan_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr (chan_addr),
    .wdata (rec),
    .raddr (chan_addr),
    .rdata (chan_rdata)
  );

  lfbe_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (s_tdata[41:34]),
    .wdata (s_tdata[15:2]),
    .raddr (rec.index),
    .rdata (tbl_rdata)
  );

  lfbe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_vld <= '0;
      tbl_vld  <= '0;
    end else begin
      if (chan_we) begin
        chan_vld[chan_addr] <= 1'b1;
      end
      if (tbl_we) begin
        tbl_vld[s_tdata[41:34]] <= 1'b1;
      end
    end
  end

  always_comb begin
    rd_rec    = chan_vld[chan_addr] ? chan_rdata : RESET_REC;
    diff      = (rec.cur > rec.tgt) ? rec.cur - rec.tgt : rec.tgt - rec.cur;
    step_use  = (rec.step < diff) ? rec.step : diff;
    count_inc = rec.count + 1'b1;
    clamp     = val[31] ? '0 :
                (val > 32'(FULL_LEVEL)) ? LEVEL_W'(FULL_LEVEL) : val[LEVEL_W-1:0];
    ms_q      = (div_quo == '0) ? FREQ_W'(1) : div_quo[FREQ_W-1:0];
    wave_num  = {1'b0, val} + (33'(ms_q) << (IDX_W - 1));
    tbl_word  = tbl_vld[rec.index] ? tbl_rdata : '0;
    cget_rec  = rd_rec;
    case (op)
      OP_TARGET: begin
        cget_rec.tgt     = clamp;
        cget_rec.pending = 1'b1;
      end
      OP_PERIOD: cget_rec.waves = waves_new;
      OP_MODE:   cget_rec.mode  = val[0];
      default: ;
    endcase
    div_go    = (accept && (s_tuser == OP_PERIOD) && (s_tdata[33:2] != 32'd0)) ||
                ((state == S_CGET) && (op == OP_TICK) && !rd_rec.mode &&
                 (rd_rec.cur != rd_rec.tgt) && rd_rec.pending) ||
                ((state == S_DIV) && div_done && (div_kind == K_MS));
    out_load  = (state == S_OUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
      div_kind  <= K_MS;
    end else begin
      div_start <= div_go;
      m_tvalid  <= out_load || (m_tvalid && !m_tready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            op      <= s_tuser;
            ch      <= ch_in;
            val     <= s_tdata[33:2];
            c       <= '0;
            wr      <= '0;
            status  <= 1'b0;
            applied <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
              duty[i] <= '0;
            end
            case (s_tuser)
              OP_TICK, OP_TARGET: state <= S_CRD;
              OP_PERIOD: begin
                if (s_tdata[33:2] == 32'd0) begin
                  status <= 1'b1;
                  state  <= S_OUT;
                end else begin
                  div_num   <= DIV_NW'(MS_PER_S);
                  div_den   <= DIV_DW'(freq_eff);
                  div_kind  <= K_MS;
                  state     <= S_DIV;
                end
              end
              OP_MODE: state <= (s_tdata[33:2] <= 32'd1) ? S_CRD : S_OUT;
              default: state <= S_OUT;
            endcase
          end
        end
        S_CRD: state <= S_CGET;
        S_CGET: begin
          rec <= cget_rec;
          case (op)
            OP_TICK: begin
              if (rd_rec.mode) begin
                state <= (rd_rec.waves == '0) ? S_NEXT : S_TRD;
              end else if (rd_rec.cur == rd_rec.tgt) begin
                state <= S_NEXT;
              end else if (rd_rec.pending) begin
                div_num   <= DIV_NW'((rd_rec.cur > rd_rec.tgt) ?
                             rd_rec.cur - rd_rec.tgt : rd_rec.tgt - rd_rec.cur);
                div_den   <= DIV_DW'(freq_eff);
                div_kind  <= K_STEP;
                state     <= S_DIV;
              end else begin
                state <= S_FADE;
              end
            end
            OP_TARGET: begin
              applied <= clamp;
              state   <= S_CWR;
            end
            default: state <= S_CWR;
          endcase
        end
        S_FADE: begin
          rec.cur <= (rec.cur > rec.tgt) ? rec.cur - step_use : rec.cur + step_use;
          duty[c] <= (rec.cur > rec.tgt) ? rec.cur - step_use : rec.cur + step_use;
          wr[c]   <= 1'b1;
          state   <= S_CWR;
        end
        S_TRD: state <= S_TGET;
        S_TGET: begin
          prod  <= DIV_NW'(tbl_word) * DIV_NW'(rec.tgt);
          state <= S_MUL;
        end
        S_MUL: begin
          lvl_prod <= prod[DIV_NW-1:PROD_SHIFT] * LVL_RECIP;
          state    <= S_LVL;
        end
        S_LVL: begin
          duty[c] <= lvl_prod[LVL_SHIFT +: LEVEL_W];
          wr[c]   <= 1'b1;
          if (count_inc >= rec.waves) begin
            rec.count <= '0;
            rec.index <= (rec.index == IDX_W'(TABLE_DEPTH - 1)) ? '0 :
                         rec.index + 1'b1;
          end else begin
            rec.count <= count_inc;
          end
          state <= S_CWR;
        end
        S_DIV: begin
          if (div_done) begin
            case (div_kind)
              K_MS: begin
                div_num   <= DIV_NW'(wave_num >> IDX_W);
                div_den   <= DIV_DW'(ms_q);
                div_kind  <= K_WAVES;
              end
              K_WAVES: begin
                waves_new <= div_quo[WAVE_W-1:0];
                state     <= S_CRD;
              end
              K_STEP: begin
                rec.step    <= (div_quo == '0) ? LEVEL_W'(1) : div_quo[LEVEL_W-1:0];
                rec.pending <= 1'b0;
                state       <= S_FADE;
              end
              default: ;
            endcase
          end
        end
        S_CWR: state <= (op == OP_TICK) ? S_NEXT : S_OUT;
        S_NEXT: begin
          if (c == CH_W'(CHANNELS - 1)) begin
            state <= S_OUT;
          end else begin
            c     <= c + 1'b1;
            state <= S_CRD;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_tuser  <= status;
            m_tdata  <= {5'b0, applied, wr, duty[2], duty[1], duty[0]};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LFBE_IMPLIES(a_div_free, div_start, !div_busy, "divider started while busy")
  `LFBE_IMPLIES(a_div_owner, div_done, state == S_DIV, "divider result not awaited")
  `LFBE_ASSERT(a_accept_leaves, accept |=> state != S_IDLE, "accepted item not taken up")
  `LFBE_IMPLIES(a_tick_ch, chan_we && op == OP_TICK, c < CH_W'(CHANNELS),
    "channel write out of range")

endmodule
